// ===== rtl/mogl_pkg.sv =====
`default_nettype none

package mogl_pkg;

    // Number of motors the block can store and drive.
    localparam int MotorNum = 4;
    localparam int MotorSlots = 4;

    localparam int DutyW = 10;
    localparam logic [DutyW-1:0] DutyMax = 10'd1023;
    localparam logic [15:0] PercentMax = 16'd100;
    localparam logic [15:0] LockoutReset = 16'd1500;
    localparam logic [15:0] ElapsedMax = 16'hFFFF;

    // floor(p * 1023 / 100) equals (p * PctRecip) >> PctShift for p in 0..100.
    localparam logic [22:0] PctRecip = 23'd5363589;
    localparam int PctShift = 19;

    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam logic [ApbAddrW-1:0] AddrLockoutTicks = 3'd0;

    typedef enum logic [1:0] {
        CMD_RAW_DUTY = 2'd0,
        CMD_PCT_DUTY = 2'd1,
        CMD_BUTTONS  = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    localparam logic [1:0] SensorModeIdle = 2'd0;
    localparam logic [1:0] SensorModeAcquiring = 2'd1;
    localparam logic [1:0] SensorModeCaptured = 2'd2;

    typedef enum logic [2:0] {
        SNS_IDLE      = 3'b001,
        SNS_ACQUIRING = 3'b010,
        SNS_CAPTURED  = 3'b100
    } sensor_fsm_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  motor_sel;
        logic [15:0] value;
        logic        gate_click;
        logic        sensor_click;
    } in_item_t;

    typedef struct packed {
        logic [DutyW-1:0] motor0_duty;
        logic [DutyW-1:0] motor1_duty;
        logic [DutyW-1:0] motor2_duty;
        logic [DutyW-1:0] motor3_duty;
        logic             gate_is_open;
        logic             lockout_on;
        logic [1:0]       sensor_mode_out;
    } out_item_t;

    // Percent (already checked to be at most 100) to 10-bit duty.
    function automatic logic [DutyW-1:0] pct_to_duty(input logic [6:0] pct);
        logic [29:0] prod;
        begin
            prod = {23'd0, pct} * {7'd0, PctRecip};
            pct_to_duty = prod[PctShift+DutyW-1:PctShift];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/motor_output_gate_with_lockout.sv =====
// Motor output gate with lockout.
//
// The input channel (in_valid, in_stall, in_item) carries one command item per
// cycle unless stalled: a raw duty write, a percent duty write, button clicks
// or a one millisecond tick. Every accepted item yields exactly one result item
// on the output channel (out_valid, out_stall, out_item) that shows the four
// motor duties, gate and lockout flags and the sensor mode after that item.
// An accepted item is registered in the input register, processed by a short
// combinational step and lands in the result register, which drives out_valid.
// While the receiver does not stall, the block takes one item every cycle; the
// only loop is the combinational state update between the input register and
// the result register.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; in_stall rises only once both are full.
// Reset clears all stored duties, closes the gate, ends any lockout, puts the
// sensor mode to idle and loads lockout_ticks with 1500.
// The lockout_ticks register sits at APB addresses 0 to 3 (only paddr[2] is decoded); pready is always high.
`default_nettype none

module motor_output_gate_with_lockout #(
    parameter int MOTOR_NUM = mogl_pkg::MotorNum
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire mogl_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mogl_pkg::out_item_t                      out_item,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mogl_pkg::ApbAddrW-1:0]       paddr,
    input  wire logic [mogl_pkg::ApbDataW-1:0]       pwdata,
    output logic      [mogl_pkg::ApbDataW-1:0]       prdata,
    output logic                                     pready
);
    import mogl_pkg::*;

    // Configuration register.
    logic [15:0] lockout_ticks_reg;

    // Input and result stages.
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;

    // Block state.
    logic [DutyW-1:0] duty_reg [MOTOR_NUM];
    logic [DutyW-1:0] duty_next [MOTOR_NUM];
    logic             gate_open_reg, gate_open_next;
    logic             lockout_reg, lockout_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [15:0]      elapsed_inc;
    sensor_fsm_t      sensor_reg, sensor_next;

    logic             duty_wr;
    logic [DutyW-1:0] duty_wr_val;
    logic             id_ok;
    logic [DutyW-1:0] shown [MotorSlots];
    logic [1:0]       mode_code;
    out_item_t        result;

    // APB port: the write lands in the access phase; reads return the register.
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[ApbAddrW-1:2] == AddrLockoutTicks[ApbAddrW-1:2])
        begin
            prdata = {{(ApbDataW-16){1'b0}}, lockout_ticks_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_ticks_reg <= LockoutReset;
        end
        else if (psel && penable && pwrite
                 && paddr[ApbAddrW-1:2] == AddrLockoutTicks[ApbAddrW-1:2])
        begin
            lockout_ticks_reg <= pwdata[15:0];
        end
    end

    // Handshake: the registered item moves on when the result slot is free or
    // being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
    end

    // Duty value for the two write commands. Percent above 100 is dropped.
    assign id_ok = ({24'd0, in_item_reg.motor_sel} < MOTOR_NUM);

    always_comb
    begin
        duty_wr     = 1'b0;
        duty_wr_val = '0;
        case (cmd_t'(in_item_reg.cmd))
            CMD_RAW_DUTY:
            begin
                duty_wr = id_ok;
                if (in_item_reg.value > {6'd0, DutyMax})
                begin
                    duty_wr_val = DutyMax;
                end
                else
                begin
                    duty_wr_val = in_item_reg.value[DutyW-1:0];
                end
            end
            CMD_PCT_DUTY:
            begin
                duty_wr     = id_ok && (in_item_reg.value <= PercentMax);
                duty_wr_val = pct_to_duty(in_item_reg.value[6:0]);
            end
            default:
            begin
                duty_wr = 1'b0;
            end
        endcase
    end

    assign elapsed_inc = (elapsed_reg == ElapsedMax) ? elapsed_reg : elapsed_reg + 16'd1;

    always_comb
    begin
        gate_open_next = gate_open_reg;
        lockout_next   = lockout_reg;
        elapsed_next   = elapsed_reg;
        sensor_next    = sensor_reg;
        for (int i = 0; i < MOTOR_NUM; i++)
        begin
            duty_next[i] = duty_reg[i];
            if (duty_wr && in_item_reg.motor_sel == 8'(i))
            begin
                duty_next[i] = duty_wr_val;
            end
        end

        if (cmd_t'(in_item_reg.cmd) == CMD_BUTTONS)
        begin
            // A gate click is ignored during the lockout.
            if (in_item_reg.gate_click && !lockout_reg)
            begin
                if (!gate_open_reg)
                begin
                    gate_open_next = 1'b1;
                    lockout_next   = 1'b1;
                    elapsed_next   = '0;
                end
                else
                begin
                    gate_open_next = 1'b0;
                    for (int i = 0; i < MOTOR_NUM; i++)
                    begin
                        duty_next[i] = '0;
                    end
                end
            end
            if (in_item_reg.sensor_click)
            begin
                case (sensor_reg)
                    SNS_IDLE:      sensor_next = SNS_ACQUIRING;
                    SNS_ACQUIRING: sensor_next = SNS_CAPTURED;
                    default:       sensor_next = SNS_ACQUIRING;
                endcase
            end
        end

        if (cmd_t'(in_item_reg.cmd) == CMD_TICK && lockout_reg)
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= lockout_ticks_reg)
            begin
                lockout_next = 1'b0;
            end
        end
    end

    // Result item from the updated state.
    always_comb
    begin
        for (int i = 0; i < MotorSlots; i++)
        begin
            shown[i] = '0;
        end
        for (int i = 0; i < MOTOR_NUM; i++)
        begin
            if (gate_open_next)
            begin
                shown[i] = duty_next[i];
            end
        end
        case (sensor_next)
            SNS_IDLE:      mode_code = SensorModeIdle;
            SNS_ACQUIRING: mode_code = SensorModeAcquiring;
            SNS_CAPTURED:  mode_code = SensorModeCaptured;
            default:       mode_code = SensorModeIdle;
        endcase
        result.motor0_duty     = shown[0];
        result.motor1_duty     = shown[1];
        result.motor2_duty     = shown[2];
        result.motor3_duty     = shown[3];
        result.gate_is_open    = gate_open_next;
        result.lockout_on      = lockout_next;
        result.sensor_mode_out = mode_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_open_reg <= 1'b0;
            lockout_reg   <= 1'b0;
            elapsed_reg   <= '0;
            sensor_reg    <= SNS_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_NUM; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                gate_open_reg <= gate_open_next;
                lockout_reg   <= lockout_next;
                elapsed_reg   <= elapsed_next;
                sensor_reg    <= sensor_next;
                for (int i = 0; i < MOTOR_NUM; i++)
                begin
                    duty_reg[i] <= duty_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire
